### src/ptdt_pkg.sv
// Shared types and constants for the periodic task delay table.
// Holds the request/response payloads, the slot entry layout and the
// controller-to-datapath command and status groups. No dependencies.
package ptdt_pkg;

  localparam int SLOTS_DEF  = 8;
  localparam int SLOT_OUT_W = 3;

  typedef struct packed {
    logic [15:0] task_id;
    logic [31:0] period_ms;
    logic [31:0] now_ms;
    logic        bypass;
  } ptdt_req_t;

  typedef struct packed {
    logic                  still_waiting;
    logic [SLOT_OUT_W-1:0] slot_used;
  } ptdt_rsp_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [31:0] period_ms;
    logic [31:0] start_ms;
  } ptdt_slot_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
    logic commit;
  } ptdt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ptdt_sts_t;

endpackage

### src/ptdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the slot table storage. No dependencies.
module ptdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ptdt_ctrl.sv
// Sequencer for the periodic task delay table: accept, scan, decide, commit.
// Depends on ptdt_pkg for the command and status groups.
module ptdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ptdt_pkg::ptdt_sts_t sts,
  output ptdt_pkg::ptdt_cmd_t cmd
);
  import ptdt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req_ready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid && req_ready) begin
            state     <= ST_SCAN;
            req_ready <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (sts.scan_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (sts.out_free) begin
            state     <= ST_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= ST_IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.start  = (state == ST_IDLE) && req_valid && req_ready;
    cmd.scan   = (state == ST_SCAN);
    cmd.decide = (state == ST_DECIDE);
    cmd.commit = (state == ST_COMMIT) && sts.out_free;
  end

endmodule

### src/ptdt_dp.sv
// Datapath of the periodic task delay table: slot RAM, valid bits, scan
// pipeline, slot selection, elapsed test and the response register.
// Depends on ptdt_pkg and ptdt_ram.
module ptdt_dp #(
  parameter int SLOTS = ptdt_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ptdt_pkg::ptdt_req_t req,
  input  ptdt_pkg::ptdt_cmd_t cmd,
  output ptdt_pkg::ptdt_sts_t sts,
  output ptdt_pkg::ptdt_rsp_t rsp,
  output logic                rsp_valid,
  input  logic                rsp_ready
);
  import ptdt_pkg::*;

  localparam int               IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam int               ENT_W    = $bits(ptdt_slot_t);

  ptdt_req_t        cur;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] chk_idx;
  logic             rd_end;
  logic             chk_vld;
  logic [SLOTS-1:0] slot_vld;
  logic             match_found;
  logic             free_found;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] free_idx;
  ptdt_slot_t       match_ent;
  ptdt_slot_t       slot0_ent;

  logic [IDX_W-1:0] sel_idx;
  logic [15:0]      sel_task;
  logic [31:0]      sel_period;
  logic             sel_wait;
  logic             sel_wr;

  logic [ENT_W-1:0] ram_q;
  ptdt_slot_t       chk_ent;
  ptdt_slot_t       wr_ent;

  logic [IDX_W-1:0] dec_idx;
  ptdt_slot_t       dec_ent;
  logic             dec_claim;
  logic [31:0]      elapsed;
  logic             dec_wait;
  logic             dec_wr;

  // Never-written slots read as the cleared entry.
  assign chk_ent = slot_vld[chk_idx] ? ptdt_slot_t'(ram_q) : '0;

  assign wr_ent.task_id   = sel_task;
  assign wr_ent.period_ms = sel_period;
  assign wr_ent.start_ms  = cur.now_ms;

  ptdt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit && sel_wr),
    .waddr (sel_idx),
    .wdata (wr_ent),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Scan: issue one read per cycle, check the entry read the cycle before.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_end      <= 1'b0;
      chk_vld     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.start) begin
      rd_end      <= 1'b0;
      chk_vld     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (cmd.scan) begin
        rd_end  <= rd_end | (rd_addr == LAST_IDX);
        chk_vld <= !rd_end;
      end else begin
        chk_vld <= 1'b0;
      end
      if (chk_vld) begin
        if (!match_found && chk_ent.task_id == cur.task_id &&
            chk_ent.period_ms == cur.period_ms) begin
          match_found <= 1'b1;
        end
        if (!free_found && chk_ent.task_id == 16'd0) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur     <= req;
      rd_addr <= '0;
    end else if (cmd.scan && rd_addr != LAST_IDX) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (cmd.scan) begin
      chk_idx <= rd_addr;
    end
    if (chk_vld) begin
      if (!match_found && chk_ent.task_id == cur.task_id &&
          chk_ent.period_ms == cur.period_ms) begin
        match_idx <= chk_idx;
        match_ent <= chk_ent;
      end
      if (!free_found && chk_ent.task_id == 16'd0) begin
        free_idx <= chk_idx;
      end
      if (chk_idx == '0) begin
        slot0_ent <= chk_ent;
      end
    end
  end

  // Slot choice: match, else slot 0 on bypass, else a free slot, else slot 0.
  always_comb begin
    dec_claim = 1'b0;
    if (match_found) begin
      dec_idx = match_idx;
      dec_ent = match_ent;
    end else if (cur.bypass || !free_found) begin
      dec_idx = '0;
      dec_ent = slot0_ent;
    end else begin
      dec_idx           = free_idx;
      dec_ent.task_id   = cur.task_id;
      dec_ent.period_ms = cur.period_ms;
      dec_ent.start_ms  = cur.now_ms;
      dec_claim         = 1'b1;
    end
    elapsed  = cur.now_ms - dec_ent.start_ms;
    dec_wait = !cur.bypass && (elapsed < dec_ent.period_ms);
    dec_wr   = cur.bypass || dec_claim || !dec_wait;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      sel_idx    <= dec_idx;
      sel_task   <= dec_ent.task_id;
      sel_period <= dec_ent.period_ms;
      sel_wait   <= dec_wait;
      sel_wr     <= dec_wr;
    end
    if (cmd.commit) begin
      rsp.still_waiting <= sel_wait;
      rsp.slot_used     <= SLOT_OUT_W'(sel_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit && sel_wr) begin
        slot_vld[sel_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.scan_done = match_found || (rd_end && !chk_vld);
  assign sts.out_free  = !rsp_valid || rsp_ready;

endmodule

### src/periodic_task_delay_table.sv
// Top level of the periodic task delay table.
// Depends on ptdt_pkg, ptdt_ctrl, ptdt_dp (and through it ptdt_ram).
//
// Usage:
//   Request channel (req_valid/req_ready, payload req): a task id, a period,
//   the current millisecond tick and a bypass flag. A request transfers when
//   req_valid and req_ready are both high at a rising clock edge.
//   Response channel (rsp_valid/rsp_ready, payload rsp): one response per
//   request, still_waiting plus the index of the serving slot.
//   The slot table lives in a RAM with registered read and is walked one
//   slot per cycle; a match ends the walk early. One request is in flight
//   at a time: req_ready returns the cycle after the commit, so the next
//   request is not taken before the previous one commits. The slot walk
//   sets the throughput.
//   The response sits in an output register: when the receiver stalls, the
//   next request is still taken and scanned, and only its commit step holds
//   until the waiting response transfers.
//   Reset (rst, synchronous) clears the controller, the response valid flag
//   and one valid flop per slot; an invalid slot reads as free (all zero),
//   so no clearing pass over the RAM is needed and requests are taken in the
//   first cycle after reset.
module periodic_task_delay_table #(
  parameter int SLOTS = ptdt_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ptdt_pkg::ptdt_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ptdt_pkg::ptdt_rsp_t rsp
);
  import ptdt_pkg::*;

  ptdt_cmd_t cmd;
  ptdt_sts_t sts;

  // Sequence each request: take it, walk the slots, pick a slot, commit.
  ptdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the table, evaluate the chosen slot and drive the response.
  ptdt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

### src/ptdt_checker.sv
// Port-level checks for the periodic task delay table, bound to the top.
// Depends on ptdt_pkg and periodic_task_delay_table.
module ptdt_checker #(
  parameter int SLOTS = ptdt_pkg::SLOTS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input ptdt_pkg::ptdt_rsp_t rsp
);
  import ptdt_pkg::*;

  logic [1:0] pending;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // Count requests whose response has not transferred yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pending <= pending + 1'b1;
    end else if (rsp_xfer && !req_xfer) begin
      pending <= pending - 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req_ready)
    else $error("request taken while previous one still in flight");

  a_no_extra_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without a pending request");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many requests outstanding");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (SLOTS > 8) || (32'(rsp.slot_used) < SLOTS))
    else $error("slot index beyond table");

endmodule

bind periodic_task_delay_table ptdt_checker #(.SLOTS(SLOTS)) u_ptdt_checker (.*);
